// ===== rtl/fssp_pkg.sv =====
// Shared types, constants and codes for the fuel-state shortest path block.
package fssp_pkg;

  localparam int MAX_CITIES = 64;
  localparam int CITY_W     = 6;
  localparam int CNT_W      = 7;
  localparam int MAX_ROADS  = 256;
  localparam int ROAD_AW    = 8;
  localparam int ROAD_CNT_W = 9;
  localparam int FUEL_W     = 4;
  localparam int LEN_W      = 8;
  localparam int PRICE_W    = 8;
  localparam int COST_W     = 18;
  localparam int STATE_AW   = CITY_W + FUEL_W;

  localparam logic [COST_W-1:0] COST_MAX = 18'h3FFFF;

  // Input operation codes.
  localparam logic [1:0] OP_LOAD_PRICE = 2'd0;
  localparam logic [1:0] OP_ADD_ROAD   = 2'd1;
  localparam logic [1:0] OP_QUERY      = 2'd2;
  localparam logic [1:0] OP_CLEAR      = 2'd3;

  // Configuration register indexes.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0] CFG_TANK_CAPACITY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CITY_COUNT    = 1'b1;

  typedef struct packed {
    logic [1:0]         op;
    logic [CITY_W-1:0]  city_index;
    logic [PRICE_W-1:0] price;
    logic [CITY_W-1:0]  road_from;
    logic [CITY_W-1:0]  road_to;
    logic [LEN_W-1:0]   road_length;
    logic [CITY_W-1:0]  source_city;
    logic [CITY_W-1:0]  dest_city;
  } in_item_t;

  typedef struct packed {
    logic [COST_W-1:0] min_cost;
    logic              reachable;
  } out_item_t;

  typedef struct packed {
    logic [CITY_W-1:0] from_city;
    logic [CITY_W-1:0] to_city;
    logic [LEN_W-1:0]  len;
  } road_t;

  typedef struct packed {
    logic              settled;
    logic              reached;
    logic [COST_W-1:0] cost;
  } st_entry_t;

endpackage

// ===== rtl/fuel_state_shortest_path.sv =====
// Cheapest refueling trip: loads prices and roads, answers queries by a Dijkstra search.
// Load-price, add-road and clear-roads items are taken while idle. A query first runs a
// clearing sweep over all 1024 entries of the state memory and a seeding step, then one
// round per settled state: a minimum scan through the single read port of the state
// memory, the settle step, the buy-fuel step when the tank is not full, a pass over the
// stored roads that relaxes toward each end of a road that the settled city matches, and
// the close of the road pass; finally it reads the destination and loads the result,
// waiting while an earlier result still waits. A query whose source or destination is
// outside the cities in use skips the search. With n cities in use and tank capacity
// cap, up to n*(cap+1) states are settled. The block takes no new item while a query
// is running.
module fuel_state_shortest_path import fssp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_CLR       = 4'd1;
  localparam logic [3:0] S_SEED      = 4'd2;
  localparam logic [3:0] S_SCAN_INIT = 4'd3;
  localparam logic [3:0] S_SCAN      = 4'd4;
  localparam logic [3:0] S_SCAN_TAIL = 4'd5;
  localparam logic [3:0] S_SETTLE    = 4'd6;
  localparam logic [3:0] S_REL_RD    = 4'd7;
  localparam logic [3:0] S_REL_WR    = 4'd8;
  localparam logic [3:0] S_ROAD_RD   = 4'd9;
  localparam logic [3:0] S_ROAD_CHK  = 4'd10;
  localparam logic [3:0] S_ROAD_DISP = 4'd11;
  localparam logic [3:0] S_FIN_RD    = 4'd12;
  localparam logic [3:0] S_FIN_WR    = 4'd13;

  // Control registers.
  logic [3:0]            state_r, state_nxt;
  logic [FUEL_W-1:0]     tank_r;
  logic [CNT_W-1:0]      ccount_r;
  logic [ROAD_CNT_W-1:0] road_cnt_r, road_cnt_nxt;
  logic                  pv_r, pv_nxt;
  logic                  found_r, found_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  h1_r, h1_nxt;
  logic                  h2_r, h2_nxt;

  // Working registers.
  logic [CNT_W-1:0]      n_r, n_nxt;
  logic [FUEL_W-1:0]     cap_r, cap_nxt;
  logic [CITY_W-1:0]     src_r, src_nxt;
  logic [CITY_W-1:0]     dst_r, dst_nxt;
  logic                  bad_r, bad_nxt;
  logic [STATE_AW-1:0]   clr_r, clr_nxt;
  logic [CITY_W-1:0]     sc_city_r, sc_city_nxt;
  logic [FUEL_W-1:0]     sc_fuel_r, sc_fuel_nxt;
  logic [STATE_AW-1:0]   paddr_r, paddr_nxt;
  logic [COST_W-1:0]     min_r, min_nxt;
  logic [STATE_AW-1:0]   u_r, u_nxt;
  logic [STATE_AW-1:0]   rel_addr_r, rel_addr_nxt;
  logic                  rel_fuel_r, rel_fuel_nxt;
  logic [3:0]            ret_r, ret_nxt;
  logic [ROAD_CNT_W-1:0] r_r, r_nxt;
  out_item_t             out_data_r, out_data_nxt;

  // Memory and cost unit connections.
  logic                  st_we, st_re;
  logic [STATE_AW-1:0]   st_waddr, st_raddr;
  st_entry_t             st_wdata, st_rdata;
  logic                  price_re, road_re;
  logic [PRICE_W-1:0]    price_q;
  road_t                 road_q, road_w;
  logic [COST_W-1:0]     alu_a, alu_y, alu_sum;
  logic [PRICE_W-1:0]    alu_b;
  logic                  alu_less;

  logic                  in_fire;
  logic [CNT_W-1:0]      n_clamp;
  logic                  road_ok;
  logic [FUEL_W-1:0]     u_fuel;
  logic [CITY_W-1:0]     u_city;
  logic                  cand_ok;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign u_fuel    = u_r[FUEL_W-1:0];
  assign u_city    = u_r[STATE_AW-1:FUEL_W];

  // Cities in use, clamped to the supported range.
  always_comb begin
    if (ccount_r == '0) begin
      n_clamp = CNT_W'(1);
    end else if (ccount_r > CNT_W'(MAX_CITIES)) begin
      n_clamp = CNT_W'(MAX_CITIES);
    end else begin
      n_clamp = ccount_r;
    end
  end

  assign road_w = '{from_city: in_data.road_from, to_city: in_data.road_to,
                    len: in_data.road_length};

  fssp_store u_store (
    .clk         (clk),
    .price_we    (in_fire && (in_data.op == OP_LOAD_PRICE)),
    .price_waddr (in_data.city_index),
    .price_wdata (in_data.price),
    .price_re    (price_re),
    .price_raddr (u_city),
    .price_rdata (price_q),
    .road_we     (in_fire && (in_data.op == OP_ADD_ROAD) &&
                  (road_cnt_r < ROAD_CNT_W'(MAX_ROADS))),
    .road_waddr  (road_cnt_r[ROAD_AW-1:0]),
    .road_wdata  (road_w),
    .road_re     (road_re),
    .road_raddr  (r_r[ROAD_AW-1:0]),
    .road_rdata  (road_q)
  );

  fssp_state_ram u_state_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  fssp_cost_alu u_alu (
    .base_cost (alu_a),
    .addend    (alu_b),
    .ref_cost  (alu_y),
    .sum       (alu_sum),
    .less      (alu_less)
  );

  // A stored road is usable from the settled state when both ends are in use and
  // the tank holds enough fuel.
  assign road_ok = ({1'b0, road_q.from_city} < n_r) && ({1'b0, road_q.to_city} < n_r) &&
                   (road_q.len <= {{(LEN_W - FUEL_W){1'b0}}, u_fuel});

  // A candidate improves an entry that is not settled and not yet reached or costlier.
  assign cand_ok = !st_rdata.settled && (!st_rdata.reached || alu_less);

  // Search sequencer.
  always_comb begin
    state_nxt     = state_r;
    road_cnt_nxt  = road_cnt_r;
    pv_nxt        = pv_r;
    found_nxt     = found_r;
    out_valid_nxt = out_valid_r;
    h1_nxt        = h1_r;
    h2_nxt        = h2_r;
    n_nxt         = n_r;
    cap_nxt       = cap_r;
    src_nxt       = src_r;
    dst_nxt       = dst_r;
    bad_nxt       = bad_r;
    clr_nxt       = clr_r;
    sc_city_nxt   = sc_city_r;
    sc_fuel_nxt   = sc_fuel_r;
    paddr_nxt     = paddr_r;
    min_nxt       = min_r;
    u_nxt         = u_r;
    rel_addr_nxt  = rel_addr_r;
    rel_fuel_nxt  = rel_fuel_r;
    ret_nxt       = ret_r;
    r_nxt         = r_r;
    out_data_nxt  = out_data_r;
    st_we         = 1'b0;
    st_waddr      = '0;
    st_wdata      = '0;
    st_re         = 1'b0;
    st_raddr      = '0;
    price_re      = 1'b0;
    road_re       = 1'b0;
    alu_a         = min_r;
    alu_b         = '0;
    alu_y         = st_rdata.cost;

    // The result register empties on a transfer.
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end

    // Scan compares the returning entry against the running minimum.
    if (state_r == S_SCAN || state_r == S_SCAN_TAIL) begin
      alu_a = st_rdata.cost;
      alu_y = min_r;
      if (pv_r && st_rdata.reached && !st_rdata.settled && (!found_r || alu_less)) begin
        found_nxt = 1'b1;
        min_nxt   = st_rdata.cost;
        u_nxt     = paddr_r;
      end
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_data.op)
            OP_ADD_ROAD: begin
              if (road_cnt_r < ROAD_CNT_W'(MAX_ROADS)) begin
                road_cnt_nxt = road_cnt_r + ROAD_CNT_W'(1);
              end
            end
            OP_CLEAR: begin
              road_cnt_nxt = '0;
            end
            OP_QUERY: begin
              n_nxt   = n_clamp;
              cap_nxt = tank_r;
              src_nxt = in_data.source_city;
              dst_nxt = in_data.dest_city;
              clr_nxt = '0;
              if (({1'b0, in_data.source_city} >= n_clamp) ||
                  ({1'b0, in_data.dest_city} >= n_clamp)) begin
                bad_nxt   = 1'b1;
                state_nxt = S_FIN_WR;
              end else begin
                bad_nxt   = 1'b0;
                state_nxt = S_CLR;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // Sweep every state entry back to unreached.
      S_CLR: begin
        st_we    = 1'b1;
        st_waddr = clr_r;
        clr_nxt  = clr_r + STATE_AW'(1);
        if (clr_r == '1) begin
          state_nxt = S_SEED;
        end
      end

      // Source city with an empty tank starts at cost zero.
      S_SEED: begin
        st_we            = 1'b1;
        st_waddr         = {src_r, {FUEL_W{1'b0}}};
        st_wdata.reached = 1'b1;
        state_nxt        = S_SCAN_INIT;
      end

      S_SCAN_INIT: begin
        sc_city_nxt = '0;
        sc_fuel_nxt = '0;
        found_nxt   = 1'b0;
        pv_nxt      = 1'b0;
        state_nxt   = S_SCAN;
      end

      // Issue one state read a cycle over the cities and fuel levels in use.
      S_SCAN: begin
        st_re     = 1'b1;
        st_raddr  = {sc_city_r, sc_fuel_r};
        pv_nxt    = 1'b1;
        paddr_nxt = {sc_city_r, sc_fuel_r};
        if (sc_fuel_r == cap_r) begin
          sc_fuel_nxt = '0;
          sc_city_nxt = sc_city_r + CITY_W'(1);
          if ({1'b0, sc_city_r} == n_r - CNT_W'(1)) begin
            state_nxt = S_SCAN_TAIL;
          end
        end else begin
          sc_fuel_nxt = sc_fuel_r + FUEL_W'(1);
        end
      end

      S_SCAN_TAIL: begin
        pv_nxt    = 1'b0;
        state_nxt = S_SETTLE;
      end

      // Mark the cheapest open state settled and start its relaxations, or finish when none is open.
      S_SETTLE: begin
        if (!found_r) begin
          state_nxt = S_FIN_RD;
        end else begin
          st_we            = 1'b1;
          st_waddr         = u_r;
          st_wdata.settled = 1'b1;
          st_wdata.reached = 1'b1;
          st_wdata.cost    = min_r;
          price_re         = 1'b1;
          r_nxt            = '0;
          if (u_fuel < cap_r) begin
            rel_addr_nxt = u_r + STATE_AW'(1);
            rel_fuel_nxt = 1'b1;
            ret_nxt      = S_ROAD_RD;
            state_nxt    = S_REL_RD;
          end else begin
            state_nxt = S_ROAD_RD;
          end
        end
      end

      S_REL_RD: begin
        st_re     = 1'b1;
        st_raddr  = rel_addr_r;
        state_nxt = S_REL_WR;
      end

      // Write the candidate cost when it improves the target entry.
      S_REL_WR: begin
        alu_b = rel_fuel_r ? price_q : '0;
        if (cand_ok) begin
          st_we            = 1'b1;
          st_waddr         = rel_addr_r;
          st_wdata.reached = 1'b1;
          st_wdata.cost    = alu_sum;
        end
        state_nxt = ret_r;
      end

      S_ROAD_RD: begin
        if (r_r == road_cnt_r) begin
          state_nxt = S_SCAN_INIT;
        end else begin
          road_re   = 1'b1;
          state_nxt = S_ROAD_CHK;
        end
      end

      S_ROAD_CHK: begin
        h1_nxt    = road_ok && (road_q.from_city == u_city);
        h2_nxt    = road_ok && (road_q.to_city == u_city);
        state_nxt = S_ROAD_DISP;
      end

      // Relax toward whichever ends of the road the settled city matches.
      S_ROAD_DISP: begin
        rel_fuel_nxt = 1'b0;
        ret_nxt      = S_ROAD_DISP;
        if (h1_r) begin
          h1_nxt       = 1'b0;
          rel_addr_nxt = {road_q.to_city, u_fuel - road_q.len[FUEL_W-1:0]};
          state_nxt    = S_REL_RD;
        end else if (h2_r) begin
          h2_nxt       = 1'b0;
          rel_addr_nxt = {road_q.from_city, u_fuel - road_q.len[FUEL_W-1:0]};
          state_nxt    = S_REL_RD;
        end else begin
          r_nxt     = r_r + ROAD_CNT_W'(1);
          state_nxt = S_ROAD_RD;
        end
      end

      S_FIN_RD: begin
        st_re     = 1'b1;
        st_raddr  = {dst_r, {FUEL_W{1'b0}}};
        state_nxt = S_FIN_WR;
      end

      // Load the result once the output register is free.
      S_FIN_WR: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          if (!bad_r && st_rdata.reached) begin
            out_data_nxt.min_cost  = st_rdata.cost;
            out_data_nxt.reachable = 1'b1;
          end else begin
            out_data_nxt.min_cost  = '0;
            out_data_nxt.reachable = 1'b0;
          end
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tank_r      <= FUEL_W'(15);
      ccount_r    <= CNT_W'(MAX_CITIES);
      road_cnt_r  <= '0;
      pv_r        <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
      h1_r        <= 1'b0;
      h2_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      road_cnt_r  <= road_cnt_nxt;
      pv_r        <= pv_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
      h1_r        <= h1_nxt;
      h2_r        <= h2_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_TANK_CAPACITY: tank_r   <= cfg_wdata[FUEL_W-1:0];
          CFG_CITY_COUNT:    ccount_r <= cfg_wdata[CNT_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Working registers of the search.
  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    cap_r      <= cap_nxt;
    src_r      <= src_nxt;
    dst_r      <= dst_nxt;
    bad_r      <= bad_nxt;
    clr_r      <= clr_nxt;
    sc_city_r  <= sc_city_nxt;
    sc_fuel_r  <= sc_fuel_nxt;
    paddr_r    <= paddr_nxt;
    min_r      <= min_nxt;
    u_r        <= u_nxt;
    rel_addr_r <= rel_addr_nxt;
    rel_fuel_r <= rel_fuel_nxt;
    ret_r      <= ret_nxt;
    r_r        <= r_nxt;
    out_data_r <= out_data_nxt;
  end

  // Road reads stay inside the stored part of the table.
  a_road_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROAD_CHK) |-> (r_r < road_cnt_r))
    else $error("road index beyond stored roads");

  // The settled state lies within the cities and fuel levels in use.
  a_settle_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SETTLE && found_r) |-> ((u_fuel <= cap_r) && ({1'b0, u_city} < n_r)))
    else $error("settled state outside the search space");

  // The clearing sweep runs to its end before seeding.
  a_clear_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR) |=> (state_r == S_CLR || state_r == S_SEED))
    else $error("clearing sweep left early");

endmodule

// ===== rtl/fssp_cost_alu.sv =====
// Shared cost unit: saturating add followed by a less-than compare.
module fssp_cost_alu import fssp_pkg::*; (
  input  logic [COST_W-1:0]  base_cost,
  input  logic [PRICE_W-1:0] addend,
  input  logic [COST_W-1:0]  ref_cost,
  output logic [COST_W-1:0]  sum,
  output logic               less
);

  logic [COST_W:0] raw;

  // Add with saturation at the largest cost, then compare to the reference.
  always_comb begin
    raw = {1'b0, base_cost} + {{(COST_W + 1 - PRICE_W){1'b0}}, addend};
    if (raw > {1'b0, COST_MAX}) begin
      sum = COST_MAX;
    end else begin
      sum = raw[COST_W-1:0];
    end
    less = (sum < ref_cost);
  end

endmodule

// ===== rtl/fssp_state_ram.sv =====
// Search state memory: one entry per (city, fuel level) pair.
module fssp_state_ram import fssp_pkg::*; (
  input  logic                clk,
  input  logic                we,
  input  logic [STATE_AW-1:0] waddr,
  input  st_entry_t           wdata,
  input  logic                re,
  input  logic [STATE_AW-1:0] raddr,
  output st_entry_t           rdata
);

  st_entry_t mem [2**STATE_AW];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/fssp_store.sv =====
// Price and road tables loaded by the input channel and read by the search.
module fssp_store import fssp_pkg::*; (
  input  logic               clk,
  input  logic               price_we,
  input  logic [CITY_W-1:0]  price_waddr,
  input  logic [PRICE_W-1:0] price_wdata,
  input  logic               price_re,
  input  logic [CITY_W-1:0]  price_raddr,
  output logic [PRICE_W-1:0] price_rdata,
  input  logic               road_we,
  input  logic [ROAD_AW-1:0] road_waddr,
  input  road_t              road_wdata,
  input  logic               road_re,
  input  logic [ROAD_AW-1:0] road_raddr,
  output road_t              road_rdata
);

  logic [PRICE_W-1:0] price_mem [MAX_CITIES];
  road_t              road_mem  [MAX_ROADS];

  // Price table.
  always_ff @(posedge clk) begin
    if (price_we) begin
      price_mem[price_waddr] <= price_wdata;
    end
    if (price_re) begin
      price_rdata <= price_mem[price_raddr];
    end
  end

  // Road table.
  always_ff @(posedge clk) begin
    if (road_we) begin
      road_mem[road_waddr] <= road_wdata;
    end
    if (road_re) begin
      road_rdata <= road_mem[road_raddr];
    end
  end

endmodule

// ===== tb/sv/fuel_state_shortest_path_test.sv =====
// Self-checking testbench for the fuel-state shortest path block.
module fuel_state_shortest_path_test;
  import fssp_pkg::*;

  localparam int NSTATE     = MAX_CITIES * 16;
  localparam int CYCLE_CAP  = 40000000;
  localparam int DRAIN_WAIT = 40;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  fuel_state_shortest_path dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Shadow copy of the block's tables and registers.
  int unsigned tank_cap_reg;
  int unsigned city_cnt_reg;
  int unsigned fuel_price[MAX_CITIES];
  int unsigned road_a[MAX_ROADS];
  int unsigned road_b[MAX_ROADS];
  int unsigned road_len[MAX_ROADS];
  int unsigned roads_stored;

  // Per-query search state.
  int unsigned trip_cost[NSTATE];
  bit          trip_settled[NSTATE];
  bit          trip_seen[NSTATE];

  out_item_t   pending_trips[$];
  int          error_count;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          hold_cycles;
  longint      cycle_count;

  // Clock generation.
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    error_count++;
  endtask

  function automatic int unsigned add_sat(input int unsigned a, input int unsigned b);
    int unsigned s;
    s = a + b;
    return (s > COST_MAX) ? COST_MAX : s;
  endfunction

  function automatic void relax_state(input int unsigned idx, input int unsigned c);
    if (trip_settled[idx]) return;
    if (!trip_seen[idx] || c < trip_cost[idx]) begin
      trip_seen[idx] = 1'b1;
      trip_cost[idx] = c;
    end
  endfunction

  // Cheapest trip from the source's empty tank to the destination's empty tank.
  function automatic out_item_t predict_trip(input int unsigned src, input int unsigned dst);
    int unsigned n, cap, span, total, u, c, f;
    bit found;
    out_item_t res;
    n = (city_cnt_reg == 0) ? 1 : (city_cnt_reg > MAX_CITIES ? MAX_CITIES : city_cnt_reg);
    cap = tank_cap_reg;
    span = cap + 1;
    total = n * span;
    res = '0;
    if (src >= n || dst >= n) return res;
    for (int i = 0; i < NSTATE; i++) begin
      trip_cost[i] = 0;
      trip_settled[i] = 1'b0;
      trip_seen[i] = 1'b0;
    end
    trip_seen[src * span] = 1'b1;
    forever begin
      found = 1'b0;
      u = 0;
      for (int unsigned i = 0; i < total; i++) begin
        if (trip_seen[i] && !trip_settled[i] && (!found || trip_cost[i] < trip_cost[u])) begin
          u = i;
          found = 1'b1;
        end
      end
      if (!found) break;
      trip_settled[u] = 1'b1;
      c = u / span;
      f = u % span;
      if (f < cap) relax_state(u + 1, add_sat(trip_cost[u], fuel_price[c]));
      for (int unsigned r = 0; r < roads_stored; r++) begin
        if (road_a[r] >= n || road_b[r] >= n || road_len[r] > f) continue;
        if (road_a[r] == c) relax_state(road_b[r] * span + (f - road_len[r]), trip_cost[u]);
        if (road_b[r] == c) relax_state(road_a[r] * span + (f - road_len[r]), trip_cost[u]);
      end
    end
    if (trip_seen[dst * span]) begin
      res.min_cost = COST_W'(trip_cost[dst * span]);
      res.reachable = 1'b1;
    end
    return res;
  endfunction

  // Update the shadow tables for one accepted item.
  function automatic void apply_item(input in_item_t it);
    case (it.op)
      OP_LOAD_PRICE: fuel_price[it.city_index] = it.price;
      OP_ADD_ROAD: begin
        if (roads_stored < MAX_ROADS) begin
          road_a[roads_stored] = it.road_from;
          road_b[roads_stored] = it.road_to;
          road_len[roads_stored] = it.road_length;
          roads_stored++;
        end
      end
      OP_CLEAR: roads_stored = 0;
      default: pending_trips.insert(pending_trips.size(),
                                    predict_trip(it.source_city, it.dest_city));
    endcase
  endfunction

  // Unused fields carry random bits.
  function automatic in_item_t make_item(input logic [1:0] op, input int unsigned a,
                                         input int unsigned b, input int unsigned c);
    in_item_t it;
    logic [63:0] rnd;
    rnd = {$urandom, $urandom};
    it = rnd[$bits(in_item_t)-1:0];
    it.op = op;
    case (op)
      OP_LOAD_PRICE: begin
        it.city_index = CITY_W'(a);
        it.price = PRICE_W'(b);
      end
      OP_ADD_ROAD: begin
        it.road_from = CITY_W'(a);
        it.road_to = CITY_W'(b);
        it.road_length = LEN_W'(c);
      end
      OP_QUERY: begin
        it.source_city = CITY_W'(a);
        it.dest_city = CITY_W'(b);
      end
      default: ;
    endcase
    return it;
  endfunction

  // Offer one item and hold it until the transfer happens.
  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    apply_item(it);
  endtask

  task automatic send_op(input logic [1:0] op, input int unsigned a = 0,
                         input int unsigned b = 0, input int unsigned c = 0);
    send_item(make_item(op, a, b, c));
  endtask

  // Wait for all results, then let the block settle before the write.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_trips.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DATA_W'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_TANK_CAPACITY) tank_cap_reg = val & 4'hF;
    else city_cnt_reg = val & 7'h7F;
  endtask

  // Cities 0 to 7 and 63 get a price first, so no query that buys fuel reads an unloaded one.
  task automatic test_load_prices();
    send_op(OP_LOAD_PRICE, 0, 0);
    send_op(OP_LOAD_PRICE, 63, 255);
    for (int i = 1; i < 8; i++) send_op(OP_LOAD_PRICE, i, $urandom_range(255));
  endtask

  // Small map: zero-length road, too-long road, road off the used range, bad endpoints.
  task automatic test_small_map();
    write_reg(CFG_TANK_CAPACITY, 15);
    write_reg(CFG_CITY_COUNT, 4);
    send_op(OP_LOAD_PRICE, 0, 10);
    send_op(OP_LOAD_PRICE, 1, 3);
    send_op(OP_LOAD_PRICE, 2, 255);
    send_op(OP_LOAD_PRICE, 3, 0);
    send_op(OP_CLEAR);
    send_op(OP_ADD_ROAD, 0, 1, 5);
    send_op(OP_ADD_ROAD, 1, 2, 15);
    send_op(OP_ADD_ROAD, 2, 3, 16);
    send_op(OP_ADD_ROAD, 1, 3, 0);
    send_op(OP_ADD_ROAD, 5, 0, 1);
    send_op(OP_ADD_ROAD, 3, 3, 255);
    send_op(OP_QUERY, 0, 0);
    send_op(OP_QUERY, 0, 3);
    send_op(OP_QUERY, 0, 2);
    send_op(OP_QUERY, 2, 0);
    send_op(OP_QUERY, 0, 4);
    send_op(OP_QUERY, 63, 0);
    // Fewer cities cuts the map; low capacity makes the long road unusable.
    write_reg(CFG_CITY_COUNT, 2);
    write_reg(CFG_TANK_CAPACITY, 4);
    send_op(OP_QUERY, 0, 1);
    send_op(OP_QUERY, 1, 0);
  endtask

  // City count zero and above the maximum, with an empty tank.
  task automatic test_count_extremes();
    write_reg(CFG_TANK_CAPACITY, 0);
    write_reg(CFG_CITY_COUNT, 0);
    send_op(OP_QUERY, 0, 0);
    send_op(OP_QUERY, 0, 1);
    write_reg(CFG_CITY_COUNT, 127);
    send_op(OP_ADD_ROAD, 63, 62, 0);
    send_op(OP_QUERY, 63, 62);
    send_op(OP_QUERY, 62, 63);
  endtask

  // A long receiver hold-off while items keep coming behind a query.
  task automatic test_output_backpressure();
    write_reg(CFG_TANK_CAPACITY, 3);
    write_reg(CFG_CITY_COUNT, 3);
    hold_cycles = 3000;
    send_op(OP_ADD_ROAD, 0, 2, 2);
    send_op(OP_QUERY, 0, 2);
    send_op(OP_QUERY, 2, 1);
    send_op(OP_LOAD_PRICE, 1, 7);
    send_op(OP_QUERY, 1, 0);
  endtask

  // Random traffic in one idling setting.
  task automatic run_random_phase(input int idle_pct, input int stall_pct, input int count);
    int unsigned n, sel, lim;
    drain();
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    write_reg(CFG_TANK_CAPACITY, $urandom_range(15));
    write_reg(CFG_CITY_COUNT, $urandom_range(8, 2));
    n = city_cnt_reg;
    for (int k = 0; k < count; k++) begin
      sel = $urandom_range(99);
      lim = (sel < 80) ? n - 1 : 63;
      if (roads_stored > 24 && sel < 40) send_op(OP_CLEAR);
      else if (sel < 15) send_op(OP_LOAD_PRICE, $urandom_range(63), $urandom_range(255));
      else if (sel < 55)
        send_op(OP_ADD_ROAD, $urandom_range(lim), $urandom_range(lim),
                (sel < 50) ? $urandom_range(tank_cap_reg + 1) : $urandom_range(255));
      else if (sel < 95) send_op(OP_QUERY, $urandom_range(lim), $urandom_range(lim));
      else send_op(OP_CLEAR);
    end
  endtask

  // Receiver: random stalls, plus a long hold-off on request.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Compare each result transfer with the oldest expected trip.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_trips.size() == 0) begin
        report_mismatch("result with none expected");
      end else begin
        out_item_t exp_trip;
        exp_trip = pending_trips.pop_front();
        if (out_data.min_cost !== exp_trip.min_cost)
          report_mismatch($sformatf("min_cost %0d, expected %0d",
                                    out_data.min_cost, exp_trip.min_cost));
        if (out_data.reachable !== exp_trip.reachable)
          report_mismatch($sformatf("reachable %0b, expected %0b",
                                    out_data.reachable, exp_trip.reachable));
      end
    end
  end

  // Cycle limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    cycle_count = 0;
    error_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 0;
    tank_cap_reg = 15;
    city_cnt_reg = 64;
    roads_stored = 0;
    for (int i = 0; i < MAX_CITIES; i++) fuel_price[i] = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_load_prices();
    test_small_map();
    test_count_extremes();
    test_output_backpressure();
    run_random_phase(0, 0, 16);
    run_random_phase(88, 0, 16);
    run_random_phase(0, 88, 16);
    run_random_phase(28, 28, 16);
    drain();
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
